// File: src/log_latency_dial_driver_unit_assert.svh
// assertion macros, clocked on clk, disabled while arst_n is low
`ifndef LOG_LATENCY_DIAL_DRIVER_UNIT_ASSERT_SVH
`define LOG_LATENCY_DIAL_DRIVER_UNIT_ASSERT_SVH

// condition holds at every edge
`define LLDD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LLDD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/lldd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lldd_pkg;

	localparam int FRAC_BITS = 16;
	localparam int LAT_W = 32;
	localparam int Y_W = FRAC_BITS + 5;
	localparam int MW = Y_W + 20;
	localparam int S_W = 26;
	localparam int CNT_W = $clog2(S_W);
	localparam int OFF_W = 24;
	localparam int ANG_W = 20;
	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int NUM_BYTES = 12;
	localparam int BIDX_W = 4;
	localparam int FILT_SHIFT = 16;

	localparam logic [LAT_W-1:0] ONE_MS = LAT_W'(64'd1 << FRAC_BITS);
	localparam logic [LAT_W-1:0] TENTH_MS = LAT_W'(((64'd1 << FRAC_BITS) + 64'd9) / 64'd10);
	localparam logic [LAT_W-1:0] LAT_MAX = LAT_W'(64'd10000 << FRAC_BITS);
	localparam logic [LAT_W-1:0] KNEE_HIGH = LAT_W'(64'd1000 << FRAC_BITS);
	localparam logic [29:0] INV_LOG2_10 = 30'h268826A1;

	localparam logic [15:0] FILT_KEEP = 16'd64880;
	localparam logic [15:0] FILT_NEW = 16'd655;
	localparam logic [15:0] FILT_HI = 16'd58982;
	localparam logic [15:0] FILT_OLD = 16'd6554;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;
	localparam logic [1:0] OP_LINK_DOWN = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_FAST_OFFSET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_OFFSET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_TURN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_ANGLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_ANGLE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_DIR = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_DIR = 3'd7;

	function automatic logic [63:0] log10_fix(input logic [63:0] xin);
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] z;
		logic [63:0] half;
		logic [63:0] one;
		int i;
		one = 64'd1 << FRAC_BITS;
		x = xin;
		y = 64'd0;
		half = one >> 1;
		if (x < one) begin
			return 64'd0;
		end
		for (i = 0; i < 64; i++) begin
			if (x >= (one << 1)) begin
				x = x >> 1;
				y = y + one;
			end
		end
		z = x;
		for (i = 0; i < FRAC_BITS; i++) begin
			z = (z * z) >> FRAC_BITS;
			if (z >= (one << 1)) begin
				z = z >> 1;
				y = y + half;
			end
			half = half >> 1;
		end
		return (y * 64'(INV_LOG2_10)) >> 31;
	endfunction

	localparam logic [Y_W-1:0] L10_KNEE = Y_W'(log10_fix(64'(KNEE_HIGH)));

	typedef struct packed {
		logic [1:0] operation;
		logic [LAT_W-1:0] sample_q16;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [OFF_W-1:0] fast_off;
		logic [OFF_W-1:0] slow_off;
		logic [OFF_W-1:0] full_turn;
		logic [ANG_W-1:0] short_ang;
		logic [ANG_W-1:0] long_ang;
		logic [BYTE_W-1:0] step;
		logic [BYTE_W-1:0] fast_dir;
		logic [BYTE_W-1:0] slow_dir;
	} cfg_t;

	typedef struct packed {
		logic apply;
		logic filt1;
		logic filt2;
		logic load;
		logic norm;
		logic sqr;
		logic l10;
		logic mult;
		logic angle;
		logic mod_step;
		logic mod_last;
		logic dial;
		logic [CNT_W-1:0] cnt;
		logic [BIDX_W-1:0] byte_idx;
	} cmd_t;

	typedef struct packed {
		logic norm_more;
	} stat_t;

	typedef struct packed {
		logic push;
		logic last;
	} emit_t;

endpackage
`default_nettype wire

// File: src/lldd_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module lldd_dp import lldd_pkg::*; (
	input wire clk,
	input wire arst_n,
	input cmd_t cmd,
	input in_item_t in_item,
	input cfg_t cfg,
	output stat_t stat,
	output logic [BYTE_W-1:0] byte_o
);

	logic [LAT_W-1:0] cur_q, avg_q;
	logic [LAT_W-1:0] x_q;
	logic [Y_W-1:0] y_q;
	logic [FRAC_BITS-1:0] half_q;
	logic [Y_W-1:0] l10_q;
	logic lo_q, hi_q;
	logic [MW-1:0] prod_a_q, prod_b_q;
	logic [S_W-1:0] sum_q;
	logic [OFF_W-1:0] rem_q;
	logic [31:0] fast_ph_q, slow_ph_q;

	logic [LAT_W-1:0] samp_c, to_c, f1, f2, hi_v, p, pt, arg_lo, arg;
	logic [LAT_W:0] to_sum;
	logic [LAT_W+16:0] f1_sum, f2_sum;
	logic lo_c, hi_c;
	logic [FRAC_BITS+1:0] z, zn;
	logic [2*FRAC_BITS+3:0] sq;
	logic [Y_W+30:0] lp;
	logic [Y_W-1:0] ma, mb;
	logic [MW:0] mid_w;
	logic [S_W-1:0] mid, pbs, ang, s;
	logic [CNT_W-1:0] idx;
	logic [OFF_W:0] r2, rn;
	logic [31:0] ph;

	always_comb begin
		samp_c = in_item.sample_q16;
		if (in_item.sample_q16 < ONE_MS) begin
			samp_c = ONE_MS;
		end else if (in_item.sample_q16 > LAT_MAX) begin
			samp_c = LAT_MAX;
		end
		to_sum = {1'b0, avg_q} + {1'b0, KNEE_HIGH};
		to_c = to_sum[LAT_W-1:0];
		if (to_sum < {1'b0, ONE_MS}) begin
			to_c = ONE_MS;
		end else if (to_sum > {1'b0, LAT_MAX}) begin
			to_c = LAT_MAX;
		end
		f1_sum = (LAT_W+17)'(avg_q) * (LAT_W+17)'(FILT_KEEP)
			+ (LAT_W+17)'(cur_q) * (LAT_W+17)'(FILT_NEW);
		f1 = f1_sum[FILT_SHIFT +: LAT_W];
		hi_v = (cur_q > avg_q) ? cur_q : avg_q;
		f2_sum = (LAT_W+17)'(hi_v) * (LAT_W+17)'(FILT_HI)
			+ (LAT_W+17)'(avg_q) * (LAT_W+17)'(FILT_OLD);
		f2 = f2_sum[FILT_SHIFT +: LAT_W];
	end

	always_comb begin
		p = cmd.dial ? avg_q : cur_q;
		lo_c = p < ONE_MS;
		hi_c = p > KNEE_HIGH;
		pt = (p < TENTH_MS) ? TENTH_MS : p;
		arg_lo = (pt << 3) + (pt << 1);
		if (lo_c) begin
			arg = arg_lo;
		end else if (hi_c && p > LAT_MAX) begin
			arg = LAT_MAX;
		end else begin
			arg = p;
		end
	end

	assign stat.norm_more = |x_q[LAT_W-1:FRAC_BITS+1];

	always_comb begin
		z = x_q[FRAC_BITS+1:0];
		sq = (2*FRAC_BITS+4)'(z) * (2*FRAC_BITS+4)'(z);
		zn = sq[FRAC_BITS +: FRAC_BITS+2];
		lp = (Y_W+31)'(y_q) * (Y_W+31)'(INV_LOG2_10);
		ma = hi_q ? L10_KNEE : l10_q;
		mb = hi_q ? (l10_q - L10_KNEE) : l10_q;
		mid_w = ((MW+1)'(cfg.short_ang) << FRAC_BITS) + (MW+1)'(prod_a_q >> 2);
		mid = S_W'(mid_w >> FRAC_BITS);
		pbs = S_W'(prod_b_q >> FRAC_BITS);
		if (lo_q) begin
			ang = pbs;
		end else if (hi_q) begin
			ang = mid + pbs;
		end else begin
			ang = mid;
		end
		s = S_W'(cmd.dial ? cfg.slow_off : cfg.fast_off) + ang;
		idx = CNT_W'(S_W - 1) - cmd.cnt;
		r2 = {rem_q, sum_q[idx]};
		rn = (r2 >= {1'b0, cfg.full_turn}) ? (r2 - {1'b0, cfg.full_turn}) : r2;
		ph = (cfg.full_turn == '0) ? 32'(sum_q) : 32'(rn[OFF_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= LAT_MAX;
			avg_q <= LAT_MAX;
		end else if (cmd.apply) begin
			case (in_item.operation)
				OP_SAMPLE: cur_q <= samp_c;
				OP_TIMEOUT: cur_q <= to_c;
				OP_LINK_DOWN: begin
					cur_q <= LAT_MAX;
					avg_q <= LAT_MAX;
				end
				default: ;
			endcase
		end else if (cmd.filt1) begin
			avg_q <= f1;
		end else if (cmd.filt2) begin
			avg_q <= f2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= arg;
			y_q <= '0;
			half_q <= FRAC_BITS'(ONE_MS >> 1);
			lo_q <= lo_c;
			hi_q <= hi_c;
		end else if (cmd.norm && stat.norm_more) begin
			x_q <= x_q >> 1;
			y_q <= y_q + Y_W'(ONE_MS);
		end else if (cmd.sqr) begin
			if (zn[FRAC_BITS+1]) begin
				x_q <= LAT_W'(zn >> 1);
				y_q <= y_q + Y_W'(half_q);
			end else begin
				x_q <= LAT_W'(zn);
			end
			half_q <= half_q >> 1;
		end
		if (cmd.l10) begin
			l10_q <= lp[31 +: Y_W];
		end
		if (cmd.mult) begin
			prod_a_q <= MW'(ma) * MW'(cfg.long_ang);
			prod_b_q <= MW'(mb) * MW'(cfg.short_ang);
		end
		if (cmd.angle) begin
			sum_q <= s;
			rem_q <= '0;
		end else if (cmd.mod_step) begin
			rem_q <= rn[OFF_W-1:0];
			if (cmd.mod_last) begin
				if (cmd.dial) begin
					slow_ph_q <= ph;
				end else begin
					fast_ph_q <= ph;
				end
			end
		end
	end

	always_comb begin
		case (cmd.byte_idx)
			4'd0: byte_o = slow_ph_q[7:0];
			4'd1: byte_o = slow_ph_q[15:8];
			4'd2: byte_o = slow_ph_q[23:16];
			4'd3: byte_o = slow_ph_q[31:24];
			4'd4: byte_o = cfg.step;
			4'd5: byte_o = cfg.slow_dir;
			4'd6: byte_o = fast_ph_q[7:0];
			4'd7: byte_o = fast_ph_q[15:8];
			4'd8: byte_o = fast_ph_q[23:16];
			4'd9: byte_o = fast_ph_q[31:24];
			4'd10: byte_o = cfg.step;
			default: byte_o = cfg.fast_dir;
		endcase
	end

endmodule
`default_nettype wire

// File: src/lldd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lldd_ctrl import lldd_pkg::*; (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire [1:0] in_op,
	output logic in_ready,
	input stat_t stat,
	input wire out_free,
	output cmd_t cmd,
	output emit_t emit
);

	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_FILT1 = 11'b00000000010,
		ST_FILT2 = 11'b00000000100,
		ST_LOAD = 11'b00000001000,
		ST_NORM = 11'b00000010000,
		ST_SQR = 11'b00000100000,
		ST_L10 = 11'b00001000000,
		ST_MULT = 11'b00010000000,
		ST_ANGLE = 11'b00100000000,
		ST_MOD = 11'b01000000000,
		ST_EMIT = 11'b10000000000
	} state_t;

	state_t st_q, st_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic dial_q, dial_d;
	logic [BIDX_W-1:0] byte_q, byte_d;
	logic accept;

	assign in_ready = (st_q == ST_IDLE);
	assign accept = in_valid && in_ready;

	always_comb begin
		st_d = st_q;
		cnt_d = cnt_q;
		dial_d = dial_q;
		byte_d = byte_q;
		cmd = '0;
		cmd.dial = dial_q;
		cmd.cnt = cnt_q;
		cmd.byte_idx = byte_q;
		emit.push = 1'b0;
		emit.last = (byte_q == BIDX_W'(NUM_BYTES - 1));
		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_op == OP_TICK) begin
						st_d = ST_FILT1;
					end else begin
						cmd.apply = 1'b1;
					end
				end
			end
			ST_FILT1: begin
				cmd.filt1 = 1'b1;
				st_d = ST_FILT2;
			end
			ST_FILT2: begin
				cmd.filt2 = 1'b1;
				dial_d = 1'b0;
				st_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				st_d = ST_NORM;
			end
			ST_NORM: begin
				cmd.norm = 1'b1;
				if (!stat.norm_more) begin
					cnt_d = '0;
					st_d = ST_SQR;
				end
			end
			ST_SQR: begin
				cmd.sqr = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(FRAC_BITS - 1)) begin
					st_d = ST_L10;
				end
			end
			ST_L10: begin
				cmd.l10 = 1'b1;
				st_d = ST_MULT;
			end
			ST_MULT: begin
				cmd.mult = 1'b1;
				st_d = ST_ANGLE;
			end
			ST_ANGLE: begin
				cmd.angle = 1'b1;
				cnt_d = '0;
				st_d = ST_MOD;
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(S_W - 1)) begin
					cmd.mod_last = 1'b1;
					if (dial_q) begin
						byte_d = '0;
						st_d = ST_EMIT;
					end else begin
						dial_d = 1'b1;
						st_d = ST_LOAD;
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					emit.push = 1'b1;
					byte_d = byte_q + 1'b1;
					if (byte_q == BIDX_W'(NUM_BYTES - 1)) begin
						st_d = ST_IDLE;
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			dial_q <= 1'b0;
			byte_q <= '0;
		end else begin
			st_q <= st_d;
			cnt_q <= cnt_d;
			dial_q <= dial_d;
			byte_q <= byte_d;
		end
	end

	`include "log_latency_dial_driver_unit_assert.svh"

	`LLDD_ASSERT_ALWAYS(a_no_push_when_ready, !(in_ready && emit.push), "item pushed while idle")
	`LLDD_ASSERT_NEXT(a_tick_starts_filter, accept && in_op == OP_TICK, st_q == ST_FILT1, "tick did not start filter")
	`LLDD_ASSERT_NEXT(a_last_byte_ends, emit.push && emit.last, st_q == ST_IDLE, "command did not end after last byte")
	`LLDD_ASSERT_NEXT(a_slow_after_fast, st_q == ST_MOD && cnt_q == CNT_W'(S_W - 1) && !dial_q, dial_q && st_q == ST_LOAD, "slow dial not started")

endmodule
`default_nettype wire

// File: src/log_latency_dial_driver_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// latency dial driver
// input channel (in_valid/in_ready, in_item): operation and sample in q16.16 ms.
// sample, timeout and link-down items update the stored latencies at the clock
// edge that accepts them and give no output; in_ready stays high.
// a tick item filters the average, computes two dial phases and then sends
// 12 command bytes on out_valid/out_ready (out_item), last set on the twelfth.
// tick sequence: filter steps, then per dial a load, normalize steps,
// 16 squaring rounds of the log unit, scaling steps and 26 remainder steps,
// then the byte sequence, using the bit-serial log and remainder units
// shared by both dials.
// one item is worked on at a time; the next is accepted once the last byte
// of a tick has entered the output register.
// a stalled receiver holds the output register and pauses the byte sequence.
// reset (arst_n low) sets both latencies to 10000 ms and config and control
// registers to defaults; cfg_we writes cfg_data into register cfg_index at once.
module log_latency_dial_driver_unit import lldd_pkg::*; (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	output logic in_ready,
	input in_item_t in_item,
	output logic out_valid,
	input wire out_ready,
	output out_item_t out_item,
	input wire cfg_we,
	input wire [CFG_IDX_W-1:0] cfg_index,
	input wire [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	cmd_t cmd;
	stat_t stat;
	emit_t emit;
	logic [BYTE_W-1:0] byte_c;
	logic out_valid_q;
	out_item_t out_item_q;
	logic out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fast_off <= OFF_W'(7500);
			cfg_q.slow_off <= OFF_W'(164400);
			cfg_q.full_turn <= OFF_W'(171990);
			cfg_q.short_ang <= ANG_W'(7500);
			cfg_q.long_ang <= ANG_W'(113500);
			cfg_q.step <= BYTE_W'(48);
			cfg_q.fast_dir <= BYTE_W'(2);
			cfg_q.slow_dir <= BYTE_W'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FAST_OFFSET: cfg_q.fast_off <= cfg_data[OFF_W-1:0];
				REG_SLOW_OFFSET: cfg_q.slow_off <= cfg_data[OFF_W-1:0];
				REG_FULL_TURN: cfg_q.full_turn <= cfg_data[OFF_W-1:0];
				REG_SHORT_ANGLE: cfg_q.short_ang <= cfg_data[ANG_W-1:0];
				REG_LONG_ANGLE: cfg_q.long_ang <= cfg_data[ANG_W-1:0];
				REG_STEP_SIZE: cfg_q.step <= cfg_data[BYTE_W-1:0];
				REG_FAST_DIR: cfg_q.fast_dir <= cfg_data[BYTE_W-1:0];
				REG_SLOW_DIR: cfg_q.slow_dir <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	lldd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_op(in_item.operation),
		.in_ready(in_ready),
		.stat(stat),
		.out_free(out_free),
		.cmd(cmd),
		.emit(emit)
	);

	lldd_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.in_item(in_item),
		.cfg(cfg_q),
		.stat(stat),
		.byte_o(byte_c)
	);

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.push) begin
			out_item_q.out_byte <= byte_c;
			out_item_q.last <= emit.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import lldd_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	log_latency_dial_driver_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	in_item_t pending_items[$];
	out_item_t command_bytes[$];
	logic [63:0] dial_reg[8];
	logic [63:0] cur_lat;
	logic [63:0] avg_lat;
	int in_idle_pct = 0;
	int out_idle_pct = 0;
	bit running = 1'b0;
	bit failed = 1'b0;
	int quiet_cycles = 0;

	localparam int QUIET_LIMIT = 6000;

	function automatic logic [63:0] log10_frac(input logic [63:0] xin);
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] z;
		logic [63:0] half;
		logic [63:0] one;
		one = 64'd1 << FRAC_BITS;
		x = xin;
		y = 0;
		half = one >> 1;
		if (x < one) begin
			return 64'd0;
		end
		while (x >= (one << 1)) begin
			x = x >> 1;
			y = y + one;
		end
		z = x;
		for (int r = 0; r < FRAC_BITS; r++) begin
			z = (z * z) >> FRAC_BITS;
			if (z >= (one << 1)) begin
				z = z >> 1;
				y = y + half;
			end
			half = half >> 1;
		end
		return (y * 64'h268826A1) >> 31;
	endfunction

	function automatic logic [63:0] middle_angle(input logic [63:0] p);
		return ((dial_reg[REG_SHORT_ANGLE] << FRAC_BITS)
			+ ((log10_frac(p) * dial_reg[REG_LONG_ANGLE]) >> 2)) >> FRAC_BITS;
	endfunction

	function automatic logic [63:0] latency_to_angle(input logic [63:0] pin);
		logic [63:0] p;
		logic [63:0] d;
		p = pin;
		if (p < 64'(ONE_MS)) begin
			if (p < 64'(TENTH_MS)) begin
				p = 64'(TENTH_MS);
			end
			return (dial_reg[REG_SHORT_ANGLE] * log10_frac(p * 10)) >> FRAC_BITS;
		end
		if (p > 64'(KNEE_HIGH)) begin
			if (p > 64'(LAT_MAX)) begin
				p = 64'(LAT_MAX);
			end
			d = log10_frac(p) - log10_frac(64'(KNEE_HIGH));
			return middle_angle(64'(KNEE_HIGH))
				+ ((dial_reg[REG_SHORT_ANGLE] * d) >> FRAC_BITS);
		end
		return middle_angle(p);
	endfunction

	function automatic logic [63:0] wrap_phase(input logic [63:0] offset, input logic [63:0] p);
		logic [63:0] s;
		s = offset + latency_to_angle(p);
		if (dial_reg[REG_FULL_TURN] == 0) begin
			return s & 64'hFFFF_FFFF;
		end
		return s % dial_reg[REG_FULL_TURN];
	endfunction

	function automatic logic [63:0] clamp_latency(input logic [63:0] v);
		if (v < 64'(ONE_MS)) begin
			return 64'(ONE_MS);
		end
		if (v > 64'(LAT_MAX)) begin
			return 64'(LAT_MAX);
		end
		return v;
	endfunction

	task automatic predict_command(input in_item_t it);
		logic [63:0] hi;
		logic [63:0] slow_ph;
		logic [63:0] fast_ph;
		logic [7:0] bytes[12];
		out_item_t e;
		case (it.operation)
			OP_SAMPLE: cur_lat = clamp_latency(64'(it.sample_q16));
			OP_TIMEOUT: cur_lat = clamp_latency(avg_lat + 64'(KNEE_HIGH));
			OP_LINK_DOWN: begin
				cur_lat = 64'(LAT_MAX);
				avg_lat = 64'(LAT_MAX);
			end
			default: begin
				avg_lat = ((64'd64880 * avg_lat + 64'd655 * cur_lat) >> 16) & 64'hFFFF_FFFF;
				hi = (cur_lat > avg_lat) ? cur_lat : avg_lat;
				avg_lat = ((64'd58982 * hi + 64'd6554 * avg_lat) >> 16) & 64'hFFFF_FFFF;
				fast_ph = wrap_phase(dial_reg[REG_FAST_OFFSET], cur_lat);
				slow_ph = wrap_phase(dial_reg[REG_SLOW_OFFSET], avg_lat);
				for (int i = 0; i < 4; i++) begin
					bytes[i] = slow_ph[8*i +: 8];
					bytes[6+i] = fast_ph[8*i +: 8];
				end
				bytes[4] = dial_reg[REG_STEP_SIZE][7:0];
				bytes[5] = dial_reg[REG_SLOW_DIR][7:0];
				bytes[10] = dial_reg[REG_STEP_SIZE][7:0];
				bytes[11] = dial_reg[REG_FAST_DIR][7:0];
				for (int k = 0; k < 12; k++) begin
					e.out_byte = bytes[k];
					e.last = (k == 11);
					command_bytes.push_back(e);
				end
			end
		endcase
	endtask

	// driver
	always @(posedge clk) begin
		if (running && (!in_valid || in_ready)) begin
			if (pending_items.size() > 0 && $urandom_range(0, 99) >= in_idle_pct) begin
				in_valid <= 1'b1;
				in_item <= pending_items.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			predict_command(in_item);
		end
	end

	// monitor
	always @(posedge clk) begin
		out_ready <= running && ($urandom_range(0, 99) >= out_idle_pct);
		if (out_valid && out_ready) begin
			if (command_bytes.size() == 0) begin
				$display("%0t: unexpected byte %02h last %0b", $time,
					out_item.out_byte, out_item.last);
				failed = 1'b1;
			end else begin
				if (out_item.out_byte !== command_bytes[0].out_byte) begin
					$display("%0t: out_byte expected %02h actual %02h", $time,
						command_bytes[0].out_byte, out_item.out_byte);
					failed = 1'b1;
				end
				if (out_item.last !== command_bytes[0].last) begin
					$display("%0t: last expected %0b actual %0b", $time,
						command_bytes[0].last, out_item.last);
					failed = 1'b1;
				end
				void'(command_bytes.pop_front());
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !running) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("log_latency_dial_driver_unit verification failed");
				$finish;
			end
		end
	end

	task automatic write_reg(input int idx, input logic [63:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data <= CFG_DATA_W'(value);
		case (idx)
			REG_FAST_OFFSET, REG_SLOW_OFFSET, REG_FULL_TURN: dial_reg[idx] = value & 64'hFFFFFF;
			REG_SHORT_ANGLE, REG_LONG_ANGLE: dial_reg[idx] = value & 64'hFFFFF;
			default: dial_reg[idx] = value & 64'hFF;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		do begin
			@(posedge clk);
			#1;
		end while (pending_items.size() > 0 || in_valid || command_bytes.size() > 0);
		repeat (160) @(posedge clk);
	endtask

	function automatic logic [31:0] random_latency();
		case ($urandom_range(0, 6))
			0: return $urandom_range(0, 32'(TENTH_MS));
			1: return $urandom_range(0, 32'(ONE_MS));
			2: return $urandom_range(32'(ONE_MS), 32'(KNEE_HIGH));
			3: return $urandom_range(32'(KNEE_HIGH), 32'(LAT_MAX));
			4: return $urandom_range(32'(LAT_MAX), 32'hFFFF_FFFF);
			5: return $urandom;
			default: return $urandom_range(32'(ONE_MS), 64 * 32'(ONE_MS));
		endcase
	endfunction

	task automatic add_item(input logic [1:0] op, input logic [31:0] value);
		in_item_t it;
		it.operation = op;
		it.sample_q16 = value;
		pending_items.push_back(it);
	endtask

	task automatic add_random_items(input int count);
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				add_item(OP_SAMPLE, random_latency());
			end else if (r < 85) begin
				add_item(OP_TICK, $urandom);
			end else if (r < 95) begin
				add_item(OP_TIMEOUT, $urandom);
			end else begin
				add_item(OP_LINK_DOWN, $urandom);
			end
		end
	endtask

	initial begin
		logic [63:0] vals[8];
		dial_reg[REG_FAST_OFFSET] = 7500;
		dial_reg[REG_SLOW_OFFSET] = 164400;
		dial_reg[REG_FULL_TURN] = 171990;
		dial_reg[REG_SHORT_ANGLE] = 7500;
		dial_reg[REG_LONG_ANGLE] = 113500;
		dial_reg[REG_STEP_SIZE] = 48;
		dial_reg[REG_FAST_DIR] = 2;
		dial_reg[REG_SLOW_DIR] = 2;
		cur_lat = 64'(LAT_MAX);
		avg_lat = 64'(LAT_MAX);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		running = 1'b1;

		// directed items under reset settings
		in_idle_pct = 23;
		out_idle_pct = 52;
		add_item(OP_TICK, 32'h0);
		add_item(OP_SAMPLE, 32'h0);
		add_item(OP_TICK, 32'hFFFF_FFFF);
		add_item(OP_SAMPLE, 32'(TENTH_MS) - 1);
		add_item(OP_TICK, 32'h0);
		add_item(OP_SAMPLE, 32'(TENTH_MS));
		add_item(OP_TICK, 32'h0);
		add_item(OP_SAMPLE, 32'(ONE_MS) - 1);
		add_item(OP_TICK, 32'h0);
		add_item(OP_SAMPLE, 32'(ONE_MS));
		add_item(OP_TICK, 32'h0);
		add_item(OP_SAMPLE, 32'(KNEE_HIGH));
		add_item(OP_TICK, 32'h0);
		add_item(OP_SAMPLE, 32'(KNEE_HIGH) + 1);
		add_item(OP_TICK, 32'h0);
		add_item(OP_SAMPLE, 32'(LAT_MAX) + 1);
		add_item(OP_TICK, 32'h0);
		add_item(OP_SAMPLE, 32'hFFFF_FFFF);
		add_item(OP_TIMEOUT, 32'h0);
		add_item(OP_TICK, 32'h0);
		add_item(OP_LINK_DOWN, 32'h0);
		add_item(OP_TIMEOUT, 32'hFFFF_FFFF);
		add_item(OP_TICK, 32'h0);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: vals = '{7500, 164400, 171990, 7500, 113500, 48, 2, 2};
				1: vals = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 20'hFFFFF, 20'hFFFFF, 255, 255, 255};
				2: vals = '{0, 0, 1, 0, 0, 0, 0, 0};
				3: vals = '{24'hFFFFFF, 24'hFFFFFF, 0, 20'hFFFFF, 20'hFFFFF, 8'hA5, 8'h5A, 8'hC3};
				default: begin
					for (int i = 0; i < 8; i++) begin
						vals[i] = $urandom;
					end
					if ($urandom_range(0, 1)) begin
						vals[REG_FULL_TURN] = $urandom_range(1, 300000);
					end
				end
			endcase
			in_idle_pct = (ph < 2) ? 23 : (ph < 4) ? 52 : 0;
			out_idle_pct = (ph < 2) ? 52 : (ph < 4) ? 23 : 0;
			for (int i = 0; i < 8; i++) begin
				write_reg(i, vals[i]);
			end
			end_writes();
			add_random_items(60);
			drain();
		end

		if (!failed) begin
			$display("log_latency_dial_driver_unit verification clean");
		end else begin
			$display("log_latency_dial_driver_unit verification failed");
		end
		$finish;
	end

endmodule
